>>> hdl/ljp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_pkg
// Shared types and constants of the Lennard-Jones pair force unit.
// ----------------------------------------------------------------------------
package ljp_pkg;

    localparam int POS_W       = 32;
    localparam int FORCE_W     = 48;
    localparam int INDEX_W     = 6;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_MAX_W = 7;

    localparam int MAX_PARTICLES_DEF = 64;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_WELL_DEPTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_DISTANCE = 2'd1;

    localparam logic [CFG_W-1:0] WELL_DEPTH_RESET    = 32'h0001_0000;
    localparam logic [CFG_W-1:0] ZERO_DISTANCE_RESET = 32'h0001_0000;

    // quotient caps of the two divisions, as powers of two
    localparam int U_CAP_SHIFT = 39;
    localparam int C_CAP_SHIFT = 63;

    // 4 * eps * 6
    localparam int EPS_SCALE = 24;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    final_particle;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        particle_index;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      anomaly;
        logic                      last_result;
    } result_t;

    // loaded set handed from front to back
    typedef struct packed {
        logic                   valid;
        logic                   ovf;
        logic [COUNT_MAX_W-1:0] n;
    } job_req_t;

    typedef struct packed {
        logic take;
        logic done;
    } job_ack_t;

endpackage

>>> hdl/ljp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ljp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> hdl/ljp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_mul
// 64 x 64 multiplier built from one 32 x 32 multiplier over four partials.
// ----------------------------------------------------------------------------
module ljp_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         pv_reg;
    logic         done_reg;
    logic [1:0]   sh_reg;
    logic [63:0]  part_reg;
    logic [127:0] acc_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [1:0]   sh;
    logic [127:0] shifted;

    always_comb
    begin
        case (cnt_reg)
            3'd0:
            begin
                pa = a[31:0];
                pb = b[31:0];
                sh = 2'd0;
            end
            3'd1:
            begin
                pa = a[31:0];
                pb = b[63:32];
                sh = 2'd1;
            end
            3'd2:
            begin
                pa = a[63:32];
                pb = b[31:0];
                sh = 2'd1;
            end
            default:
            begin
                pa = a[63:32];
                pb = b[63:32];
                sh = 2'd2;
            end
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            2'd0:    shifted = {64'b0, part_reg};
            2'd1:    shifted = {32'b0, part_reg, 32'b0};
            default: shifted = {part_reg, 64'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 3'd4)
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    pv_reg  <= 1'b1;
                end
                else
                begin
                    pv_reg   <= 1'b0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + shifted;
        end
        part_reg <= pa * pb;
        sh_reg   <= sh;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hdl/ljp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_div
// Restoring divider, one quotient bit per cycle, quotient capped at 2^k.
// ----------------------------------------------------------------------------
module ljp_div import ljp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         mode,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [63:0]  quot,
    output logic         sat
);

    logic         busy_reg;
    logic         done_reg;
    logic         sat_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  low_reg;
    logic [63:0]  q_reg;

    logic [127:0] hk;
    logic [127:0] rem0;
    logic [63:0]  low0;
    logic [6:0]   steps;
    logic [63:0]  cap;
    logic         sat_now;
    logic [64:0]  t;
    logic [64:0]  diff;
    logic         ge;

    always_comb
    begin
        // mode high: coefficient division, else the u division
        if (mode)
        begin
            hk    = num >> C_CAP_SHIFT;
            rem0  = num >> (C_CAP_SHIFT + 1);
            low0  = num[63:0] << (63 - C_CAP_SHIFT);
            steps = 7'(C_CAP_SHIFT + 1);
            cap   = 64'(1) << C_CAP_SHIFT;
        end
        else
        begin
            hk    = num >> U_CAP_SHIFT;
            rem0  = num >> (U_CAP_SHIFT + 1);
            low0  = num[63:0] << (63 - U_CAP_SHIFT);
            steps = 7'(U_CAP_SHIFT + 1);
            cap   = 64'(1) << U_CAP_SHIFT;
        end
        sat_now = (hk[127:64] != '0) || (hk[63:0] >= den);
        t       = {rem_reg, low_reg[63]};
        diff    = t - {1'b0, den};
        ge      = t >= {1'b0, den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (sat_now)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= steps;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= sat_now;
            q_reg   <= sat_now ? cap : '0;
            rem_reg <= rem0[63:0];
            low_reg <= low0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : t[63:0];
            q_reg   <= {q_reg[62:0], ge};
            low_reg <= {low_reg[62:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign sat  = sat_reg;

endmodule

>>> hdl/ljp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_front
// Load side: stores positions, counts the set and hands it to the back end.
// ----------------------------------------------------------------------------
module ljp_front import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  in_item_t                         item,
    output logic                             we,
    output logic [$clog2(MAX_PARTICLES)-1:0] waddr,
    output logic [3*POS_W-1:0]               wdata,
    output job_req_t                         job,
    input  job_ack_t                         ack
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          lock_reg;
    logic          job_valid_reg;
    logic          job_ovf_reg;
    logic [CW-1:0] job_n_reg;

    logic accept;
    logic room;

    assign accept = push && !lock_reg;
    assign room   = count_reg < CW'(MAX_PARTICLES);

    assign full  = lock_reg;
    assign we    = accept && room;
    assign waddr = count_reg[AW-1:0];
    assign wdata = {item.pos_x, item.pos_y, item.pos_z};

    assign job.valid = job_valid_reg;
    assign job.ovf   = job_ovf_reg;
    assign job.n     = COUNT_MAX_W'(job_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            lock_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
            job_ovf_reg   <= 1'b0;
            job_n_reg     <= '0;
        end
        else
        begin
            if (ack.take)
            begin
                job_valid_reg <= 1'b0;
            end
            if (ack.done)
            begin
                lock_reg <= 1'b0;
            end
            if (accept)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (item.final_particle)
                begin
                    job_valid_reg <= 1'b1;
                    job_ovf_reg   <= ovf_reg || !room;
                    job_n_reg     <= room ? count_reg + CW'(1) : count_reg;
                    count_reg     <= '0;
                    ovf_reg       <= 1'b0;
                    lock_reg      <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/ljp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_back
// Force sequencer: walks all pairs of a set through the shared multiplier
// and divider, accumulates per particle and queues the results.
// ----------------------------------------------------------------------------
module ljp_back import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  job_req_t                         job,
    output job_ack_t                         ack,
    output logic [$clog2(MAX_PARTICLES)-1:0] raddr,
    input  logic [3*POS_W-1:0]               rdata,
    input  logic [CFG_W-1:0]                 well_depth,
    input  logic [CFG_W-1:0]                 zero_distance,
    output logic                             empty,
    input  logic                             pop,
    output result_t                          result
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDI   = 4'd1;
    localparam logic [3:0] ST_LDI   = 4'd2;
    localparam logic [3:0] ST_NEXTJ = 4'd3;
    localparam logic [3:0] ST_LDJ   = 4'd4;
    localparam logic [3:0] ST_MWAIT = 4'd5;
    localparam logic [3:0] ST_DWAIT = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    localparam logic [3:0] OP_SQ0 = 4'd0;
    localparam logic [3:0] OP_SQ1 = 4'd1;
    localparam logic [3:0] OP_SQ2 = 4'd2;
    localparam logic [3:0] OP_S2  = 4'd3;
    localparam logic [3:0] OP_DU  = 4'd4;
    localparam logic [3:0] OP_U2  = 4'd5;
    localparam logic [3:0] OP_U3  = 4'd6;
    localparam logic [3:0] OP_U6  = 4'd7;
    localparam logic [3:0] OP_CM  = 4'd8;
    localparam logic [3:0] OP_DC  = 4'd9;
    localparam logic [3:0] OP_F0  = 4'd10;
    localparam logic [3:0] OP_F1  = 4'd11;
    localparam logic [3:0] OP_F2  = 4'd12;

    localparam logic signed [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    logic [3:0]    state_reg;
    logic [3:0]    op_reg;
    logic [CW-1:0] n_reg;
    logic          ovf_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [3*POS_W-1:0] pi_reg;
    logic [31:0]   dmag_reg [3];
    logic          dneg_reg [3];
    logic signed [FORCE_W-1:0] acc_reg [3];
    logic          flag_reg;
    logic [63:0]   r2_reg;
    logic [63:0]   u_reg;
    logic [63:0]   u3_reg;
    logic          gneg_reg;

    logic          mul_start_reg;
    logic [63:0]   mul_a_reg;
    logic [63:0]   mul_b_reg;
    logic          div_start_reg;
    logic          div_mode_reg;
    logic [127:0]  div_num_reg;
    logic [63:0]   div_den_reg;

    result_t       fifo_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    fcnt_reg;

    logic          mul_done;
    logic [127:0]  mul_prod;
    logic          div_done;
    logic [63:0]   div_quot;
    logic          div_sat;

    // pair differences
    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] dy;
    logic signed [POS_W:0] dz;
    logic signed [POS_W:0] dabs_x;
    logic signed [POS_W:0] dabs_y;
    logic signed [POS_W:0] dabs_z;

    // distance square accumulate
    logic [64:0]   r2_sum;
    logic [63:0]   r2_new;
    logic          r2_ovf;

    // g = 2 u^6 - u^3
    logic [63:0]   u6;
    logic [63:0]   two6;
    logic [63:0]   u3f;
    logic          gneg_new;
    logic [63:0]   gmag;
    logic [36:0]   eps24;

    // force component
    logic          comp_sat;
    logic [FORCE_W-1:0] comp_mag;
    logic [FORCE_W+1:0] comp_ext;
    logic [FORCE_W+1:0] comp_sv;
    logic [FORCE_W+1:0] acc_sum;
    logic          acc_hi;
    logic          acc_lo;
    logic signed [FORCE_W-1:0] acc_new;

    logic          fifo_full;
    logic          is_last;
    result_t       res_new;

    ljp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ljp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .mode  (div_mode_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    assign raddr = (state_reg == ST_RDI) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    always_comb
    begin
        dx = $signed({pi_reg[95], pi_reg[95:64]}) - $signed({rdata[95], rdata[95:64]});
        dy = $signed({pi_reg[63], pi_reg[63:32]}) - $signed({rdata[63], rdata[63:32]});
        dz = $signed({pi_reg[31], pi_reg[31:0]}) - $signed({rdata[31], rdata[31:0]});
        dabs_x = dx[POS_W] ? -dx : dx;
        dabs_y = dy[POS_W] ? -dy : dy;
        dabs_z = dz[POS_W] ? -dz : dz;

        r2_sum = {1'b0, r2_reg} + {1'b0, mul_prod[63:0]};
        r2_ovf = r2_sum[64];
        r2_new = r2_ovf ? '1 : r2_sum[63:0];

        u6       = mul_prod[107:44];
        two6     = {u6[62:0], 1'b0};
        u3f      = {12'b0, u3_reg[63:12]};
        gneg_new = two6 < u3f;
        gmag     = gneg_new ? u3f - two6 : two6 - u3f;
        eps24    = 37'(well_depth) * 37'(EPS_SCALE);

        // component magnitude capped at 2^47
        comp_sat = mul_prod[127:63] != '0;
        comp_mag = comp_sat ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, mul_prod[62:16]};
        comp_ext = {2'b00, comp_mag};
        comp_sv  = (gneg_reg != dneg_reg[0]) ? -comp_ext : comp_ext;
        acc_sum  = comp_sv + {{2{acc_reg[0][FORCE_W-1]}}, acc_reg[0]};
        acc_hi   = !acc_sum[FORCE_W+1] && (acc_sum[FORCE_W:FORCE_W-1] != 2'b00);
        acc_lo   = acc_sum[FORCE_W+1] && (acc_sum[FORCE_W:FORCE_W-1] != 2'b11);
        acc_new  = acc_hi ? F_MAX : (acc_lo ? F_MIN : $signed(acc_sum[FORCE_W-1:0]));
    end

    assign fifo_full = fcnt_reg == 2'd2;
    assign is_last   = i_reg == n_reg - CW'(1);

    always_comb
    begin
        res_new.particle_index = INDEX_W'(i_reg);
        res_new.force_x        = acc_reg[0];
        res_new.force_y        = acc_reg[1];
        res_new.force_z        = acc_reg[2];
        res_new.anomaly        = flag_reg;
        res_new.last_result    = is_last;
    end

    assign ack.take = (state_reg == ST_IDLE) && job.valid;
    assign ack.done = (state_reg == ST_OUT) && !fifo_full && is_last;

    assign empty  = fcnt_reg == 2'd0;
    assign result = fifo_reg[rptr_reg];

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SQ0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job.valid)
                    begin
                        n_reg     <= CW'(job.n);
                        ovf_reg   <= job.ovf;
                        i_reg     <= '0;
                        state_reg <= ST_RDI;
                    end
                end
                ST_RDI:
                begin
                    state_reg <= ST_LDI;
                end
                ST_LDI:
                begin
                    j_reg     <= '0;
                    state_reg <= ST_NEXTJ;
                end
                ST_NEXTJ:
                begin
                    if (j_reg == n_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (j_reg == i_reg)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_LDJ;
                    end
                end
                ST_LDJ:
                begin
                    mul_start_reg <= 1'b1;
                    op_reg        <= OP_SQ0;
                    state_reg     <= ST_MWAIT;
                end
                ST_MWAIT:
                begin
                    if (mul_done)
                    begin
                        case (op_reg)
                            OP_SQ0:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_SQ1;
                            end
                            OP_SQ1:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_SQ2;
                            end
                            OP_SQ2:
                            begin
                                if (r2_new == '0)
                                begin
                                    // coincident pair is skipped
                                    j_reg     <= j_reg + CW'(1);
                                    state_reg <= ST_NEXTJ;
                                end
                                else
                                begin
                                    mul_start_reg <= 1'b1;
                                    op_reg        <= OP_S2;
                                end
                            end
                            OP_S2:
                            begin
                                div_start_reg <= 1'b1;
                                op_reg        <= OP_DU;
                                state_reg     <= ST_DWAIT;
                            end
                            OP_U2:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_U3;
                            end
                            OP_U3:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_U6;
                            end
                            OP_U6:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_CM;
                            end
                            OP_CM:
                            begin
                                div_start_reg <= 1'b1;
                                op_reg        <= OP_DC;
                                state_reg     <= ST_DWAIT;
                            end
                            OP_F0:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_F1;
                            end
                            OP_F1:
                            begin
                                mul_start_reg <= 1'b1;
                                op_reg        <= OP_F2;
                            end
                            OP_F2:
                            begin
                                j_reg     <= j_reg + CW'(1);
                                state_reg <= ST_NEXTJ;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DWAIT:
                begin
                    if (div_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MWAIT;
                        op_reg        <= (op_reg == OP_DU) ? OP_U2 : OP_F0;
                    end
                end
                ST_OUT:
                begin
                    if (!fifo_full)
                    begin
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= ST_RDI;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LDI:
            begin
                pi_reg     <= rdata;
                acc_reg[0] <= '0;
                acc_reg[1] <= '0;
                acc_reg[2] <= '0;
                flag_reg   <= ovf_reg;
            end
            ST_LDJ:
            begin
                dmag_reg[0] <= dabs_x[POS_W-1:0];
                dmag_reg[1] <= dabs_y[POS_W-1:0];
                dmag_reg[2] <= dabs_z[POS_W-1:0];
                dneg_reg[0] <= dx[POS_W];
                dneg_reg[1] <= dy[POS_W];
                dneg_reg[2] <= dz[POS_W];
                r2_reg      <= '0;
                mul_a_reg   <= 64'(dabs_x[POS_W-1:0]);
                mul_b_reg   <= 64'(dabs_x[POS_W-1:0]);
            end
            ST_MWAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_SQ0, OP_SQ1, OP_SQ2:
                        begin
                            r2_reg <= r2_new;
                            if (r2_ovf || (op_reg == OP_SQ2 && r2_new == '0))
                            begin
                                flag_reg <= 1'b1;
                            end
                            if (op_reg == OP_SQ0)
                            begin
                                mul_a_reg <= 64'(dmag_reg[1]);
                                mul_b_reg <= 64'(dmag_reg[1]);
                            end
                            else if (op_reg == OP_SQ1)
                            begin
                                mul_a_reg <= 64'(dmag_reg[2]);
                                mul_b_reg <= 64'(dmag_reg[2]);
                            end
                            else
                            begin
                                mul_a_reg <= 64'(zero_distance);
                                mul_b_reg <= 64'(zero_distance);
                            end
                        end
                        OP_S2:
                        begin
                            div_num_reg  <= {32'b0, mul_prod[63:0], 32'b0};
                            div_den_reg  <= r2_reg;
                            div_mode_reg <= 1'b0;
                        end
                        OP_U2:
                        begin
                            mul_a_reg <= mul_prod[95:32];
                            mul_b_reg <= u_reg;
                        end
                        OP_U3:
                        begin
                            u3_reg    <= mul_prod[95:32];
                            mul_a_reg <= mul_prod[95:32];
                            mul_b_reg <= mul_prod[95:32];
                        end
                        OP_U6:
                        begin
                            gneg_reg  <= gneg_new;
                            mul_a_reg <= 64'(eps24);
                            mul_b_reg <= gmag;
                        end
                        OP_CM:
                        begin
                            div_num_reg  <= {mul_prod[107:0], 20'b0};
                            div_mode_reg <= 1'b1;
                        end
                        OP_F0, OP_F1, OP_F2:
                        begin
                            // handle lane 0, then rotate the lanes
                            acc_reg[0]  <= acc_reg[1];
                            acc_reg[1]  <= acc_reg[2];
                            acc_reg[2]  <= acc_new;
                            dmag_reg[0] <= dmag_reg[1];
                            dmag_reg[1] <= dmag_reg[2];
                            dmag_reg[2] <= dmag_reg[0];
                            dneg_reg[0] <= dneg_reg[1];
                            dneg_reg[1] <= dneg_reg[2];
                            dneg_reg[2] <= dneg_reg[0];
                            mul_b_reg   <= 64'(dmag_reg[1]);
                            if (comp_sat || acc_hi || acc_lo)
                            begin
                                flag_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            flag_reg <= flag_reg;
                        end
                    endcase
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    mul_a_reg <= div_quot;
                    if (op_reg == OP_DU)
                    begin
                        u_reg     <= div_quot;
                        mul_b_reg <= div_quot;
                        if (div_sat)
                        begin
                            flag_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        mul_b_reg <= 64'(dmag_reg[0]);
                    end
                end
            end
            default:
            begin
                pi_reg <= pi_reg;
            end
        endcase
    end

    // two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fcnt_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT && !fifo_full)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop && !empty)
            begin
                rptr_reg <= !rptr_reg;
            end
            fcnt_reg <= fcnt_reg + 2'((state_reg == ST_OUT) && !fifo_full)
                                 - 2'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && !fifo_full)
        begin
            fifo_reg[wptr_reg] <= res_new;
        end
    end

endmodule

>>> hdl/lennard_jones_pair_forces_unit.sv
`timescale 1ns / 1ps
// a load is accepted whenever full is low; full stays high from the final load until the set is done
// each pair takes 11 products on one 32 x 32 multiplier in four
//   partials, plus two bit-serial divisions of 40 and 64 steps
// results of a set leave in load order
// reset (rst_n low, asynchronous) empties the set and queues, loads 1.0 into both registers
// ----------------------------------------------------------------------------
// lennard_jones_pair_forces_unit
// All-pairs Lennard-Jones force unit: a load front end fills the position
// store, a force back end walks every pair and emits one result per particle.
// ----------------------------------------------------------------------------
module lennard_jones_pair_forces_unit import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // load side: one position per transfer
    input  logic                   push,
    output logic                   full,
    input  in_item_t               item,
    // result side: one force per transfer
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    // configuration writes
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]       wr_data
);

    localparam int AW = $clog2(MAX_PARTICLES);

    // epsilon and sigma, unsigned Q16.16
    logic [CFG_W-1:0] well_depth_reg;
    logic [CFG_W-1:0] zero_distance_reg;

    // position store, x in the top word, z in the bottom
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [3*POS_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [3*POS_W-1:0] ram_rdata;

    // set handoff between front and back
    job_req_t job;
    job_ack_t ack;

    // the user must change the registers only while the unit is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_depth_reg    <= WELL_DEPTH_RESET;
            zero_distance_reg <= ZERO_DISTANCE_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_WELL_DEPTH)
            begin
                well_depth_reg <= wr_data;
            end
            else if (wr_index == REG_ZERO_DISTANCE)
            begin
                zero_distance_reg <= wr_data;
            end
        end
    end

    ljp_ram #(
        .WIDTH (3 * POS_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // load front end: drops loads past capacity and marks the set
    ljp_front #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .job   (job),
        .ack   (ack)
    );

    // force back end with its own result queue
    ljp_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .ack           (ack),
        .raddr         (ram_raddr),
        .rdata         (ram_rdata),
        .well_depth    (well_depth_reg),
        .zero_distance (zero_distance_reg),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

>>> sim/ljp_force_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljp_force_checker
// Watches the load, result and register ports, mirrors the position store and
// predicts every per-particle force, then compares each result transfer.
// ----------------------------------------------------------------------------
module ljp_force_checker import ljp_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  in_item_t               item,
    input  logic                   empty,
    input  logic                   pop,
    input  result_t                result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]       wr_data,
    output int                     fails,
    output int                     pending,
    output int                     checked
);

    logic signed [POS_W-1:0] pos_x_mem [MAX_PARTICLES_DEF];
    logic signed [POS_W-1:0] pos_y_mem [MAX_PARTICLES_DEF];
    logic signed [POS_W-1:0] pos_z_mem [MAX_PARTICLES_DEF];
    int                      loaded = 0;
    bit                      dropped = 0;
    logic [CFG_W-1:0]        eps = WELL_DEPTH_RESET;
    logic [CFG_W-1:0]        sigma = ZERO_DISTANCE_RESET;
    longint                  acc [3];
    bit                      flag;
    result_t                 force_queue [$];

    initial fails = 0;
    initial checked = 0;
    initial pending = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
        fails++;
    endtask

    // adds the force of particle j on particle i into acc
    function automatic void add_pair(input int i, input int j);
        longint       d [3];
        logic [63:0]  r2, s2, u, u2, u3, u6, two6, u3f, gmag, c, m;
        logic [64:0]  t;
        logic [127:0] num, prod, q;
        bit           gneg;
        longint       v;
        d[0] = longint'(pos_x_mem[i]) - longint'(pos_x_mem[j]);
        d[1] = longint'(pos_y_mem[i]) - longint'(pos_y_mem[j]);
        d[2] = longint'(pos_z_mem[i]) - longint'(pos_z_mem[j]);
        r2 = '0;
        for (int k = 0; k < 3; k++)
        begin
            m = (d[k] < 0) ? -d[k] : d[k];
            t = {1'b0, r2} + {1'b0, m * m};
            if (t[64])
            begin
                r2 = '1;
                flag = 1;
            end
            else
                r2 = t[63:0];
        end
        // coincident pair is skipped
        if (r2 == 0)
        begin
            flag = 1;
            return;
        end
        s2 = {32'b0, sigma} * {32'b0, sigma};
        num = {32'b0, s2, 32'b0};
        if (num >= ({64'b0, r2} << U_CAP_SHIFT))
        begin
            u = 64'd1 << U_CAP_SHIFT;
            flag = 1;
        end
        else
            u = 64'(num / r2);
        prod = {64'b0, u} * {64'b0, u};
        u2 = 64'(prod >> 32);
        prod = {64'b0, u2} * {64'b0, u};
        u3 = 64'(prod >> 32);
        prod = {64'b0, u3} * {64'b0, u3};
        u6 = 64'(prod >> 44);
        two6 = u6 << 1;
        u3f = u3 >> 12;
        gneg = two6 < u3f;
        gmag = gneg ? u3f - two6 : two6 - u3f;
        num = ({64'b0, {32'b0, eps} * 64'(EPS_SCALE)} * {64'b0, gmag}) << 20;
        // coefficient cap carries no flag of its own
        if (num >= ({64'b0, r2} << C_CAP_SHIFT))
            c = 64'd1 << C_CAP_SHIFT;
        else
            c = 64'(num / r2);
        for (int k = 0; k < 3; k++)
        begin
            m = (d[k] < 0) ? -d[k] : d[k];
            prod = {64'b0, c} * {64'b0, m};
            q = prod >> 16;
            if (q >= (128'd1 << 47))
            begin
                m = 64'd1 << 47;
                flag = 1;
            end
            else
                m = q[63:0];
            v = (gneg != (d[k] < 0)) ? -longint'(m) : longint'(m);
            v += acc[k];
            if (v > (64'sd1 << 47) - 1)
            begin
                v = (64'sd1 << 47) - 1;
                flag = 1;
            end
            if (v < -(64'sd1 << 47))
            begin
                v = -(64'sd1 << 47);
                flag = 1;
            end
            acc[k] = v;
        end
    endfunction

    function automatic void predict_forces();
        result_t r;
        for (int i = 0; i < loaded; i++)
        begin
            acc = '{0, 0, 0};
            flag = dropped;
            for (int j = 0; j < loaded; j++)
                if (j != i)
                    add_pair(i, j);
            r.particle_index = INDEX_W'(i);
            r.force_x = acc[0][FORCE_W-1:0];
            r.force_y = acc[1][FORCE_W-1:0];
            r.force_z = acc[2][FORCE_W-1:0];
            r.anomaly = flag;
            r.last_result = (i + 1 == loaded);
            force_queue.push_back(r);
        end
        loaded = 0;
        dropped = 0;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (wr_en)
            begin
                if (wr_index == REG_WELL_DEPTH)
                    eps = wr_data;
                else if (wr_index == REG_ZERO_DISTANCE)
                    sigma = wr_data;
            end
            if (pop && !empty)
            begin
                if (force_queue.size() == 0)
                    report_mismatch("unexpected result", 64'(result.particle_index), '0);
                else
                begin
                    want = force_queue.pop_front();
                    checked++;
                    if (result.particle_index !== want.particle_index)
                        report_mismatch("particle_index", 64'(result.particle_index),
                                        64'(want.particle_index));
                    if (result.force_x !== want.force_x)
                        report_mismatch("force_x", 64'(result.force_x), 64'(want.force_x));
                    if (result.force_y !== want.force_y)
                        report_mismatch("force_y", 64'(result.force_y), 64'(want.force_y));
                    if (result.force_z !== want.force_z)
                        report_mismatch("force_z", 64'(result.force_z), 64'(want.force_z));
                    if (result.anomaly !== want.anomaly)
                        report_mismatch("anomaly", 64'(result.anomaly), 64'(want.anomaly));
                    if (result.last_result !== want.last_result)
                        report_mismatch("last_result", 64'(result.last_result),
                                        64'(want.last_result));
                end
            end
            if (push && !full)
            begin
                if (loaded < MAX_PARTICLES_DEF)
                begin
                    pos_x_mem[loaded] = item.pos_x;
                    pos_y_mem[loaded] = item.pos_y;
                    pos_z_mem[loaded] = item.pos_z;
                    loaded++;
                end
                else
                    dropped = 1;
                if (item.final_particle)
                    predict_forces();
            end
            pending = force_queue.size();
        end
    end

endmodule

>>> sim/tb_lennard_jones_pair_forces_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lennard_jones_pair_forces_unit
// Drives position sets into the pair force unit under random gaps and result
// stalls, across several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_lennard_jones_pair_forces_unit;
    import ljp_pkg::*;

    // indexes past the two registers, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int Q_ONE = 32'h0001_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    in_item_t               item;
    logic                   empty;
    logic                   pop;
    result_t                result;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_W-1:0]       wr_data;

    int fails;
    int pending;
    int checked;
    int cycles = 0;
    int items_sent = 0;
    int sets_sent = 0;
    bit hold_results = 0;

    lennard_jones_pair_forces_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    ljp_force_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .fails    (fails),
        .pending  (pending),
        .checked  (checked)
    );

    // 8 ns clock
    initial clk = 0;
    always #4 clk = ~clk;

    // run limit, generous against the slowest correct run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d forces still expected", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // result side: random pop with changing stall density, plus a long hold-off
    initial
    begin
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                // receiver holds off while the sender keeps offering loads
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        2: stall_pct = 70;
                        default: stall_pct = 95;
                    endcase
                    stretch = $urandom_range(20, 300);
                end
                stretch--;
                pop <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // offer one load and hold it until the transfer happens
    task automatic push_pos(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [POS_W-1:0] z, input logic fin);
        item <= '{pos_x: x, pos_y: y, pos_z: z, final_particle: fin};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (fin)
            sets_sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // mostly a few unit cells around the origin, sometimes any 32-bit value
    function automatic logic [POS_W-1:0] rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
        begin
            push_pos(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
            idle_gap();
        end
    endtask

    task automatic send_random_until(input int target);
        while (items_sent < target)
            send_set(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6));
    endtask

    // only while idle: every force transfered, then a short settle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_WELL_DEPTH;
        wr_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets under reset settings
        // single particle, zero force
        push_pos(Q_ONE, Q_ONE, Q_ONE, 1'b1);
        // pair exactly sigma apart
        push_pos(32'h0, 32'h0, 32'h0, 1'b0);
        push_pos(Q_ONE, 32'h0, 32'h0, 1'b1);
        // coincident pair beside a third particle
        push_pos(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
        push_pos(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
        push_pos(32'h0, 32'h0001_8000, 32'h0, 1'b1);
        // opposite corners, squared distance beyond 64 bits
        push_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        // one lsb apart, ratio capped
        push_pos(32'h0, 32'h0, 32'h0, 1'b0);
        push_pos(32'h1, 32'h0, 32'h0, 1'b1);
        // mixed signs near the minimum of the well
        push_pos(32'hFFFE_0000, 32'h0001_8000, 32'hFFFF_C000, 1'b0);
        push_pos(32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000, 1'b0);
        push_pos(32'h0001_2000, 32'h0000_4000, 32'h0000_E000, 1'b1);
        idle_gap();
        send_random_until(items_sent + 40);
        // more loads than the store holds, every force flagged
        send_set(MAX_PARTICLES_DEF + 2);

        // zero well depth
        write_reg(REG_WELL_DEPTH, 32'h0);
        write_reg(REG_ZERO_DISTANCE, Q_ONE);
        send_random_until(items_sent + 65);

        // full-scale settings, spare indexes written too
        write_reg(REG_WELL_DEPTH, 32'hFFFF_FFFF);
        write_reg(REG_ZERO_DISTANCE, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_2, $urandom);
        write_reg(REG_SPARE_3, $urandom);
        send_random_until(items_sent + 65);

        // half depth, sigma 1.5, with a long result stall while loads keep coming
        write_reg(REG_WELL_DEPTH, 32'h0000_8000);
        write_reg(REG_ZERO_DISTANCE, 32'h0001_8000);
        hold_results = 1;
        send_set(4);
        send_set(3);
        send_random_until(items_sent + 58);

        // random settings
        write_reg(REG_WELL_DEPTH, $urandom);
        write_reg(REG_ZERO_DISTANCE, $urandom_range(32'h0000_8000, 32'h0004_0000));
        send_random_until(items_sent + 65);

        // zero sigma, the repulsive term vanishes with the attractive one
        write_reg(REG_WELL_DEPTH, Q_ONE);
        write_reg(REG_ZERO_DISTANCE, 32'h0);
        send_random_until(items_sent + 65);

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d positions loaded in %0d sets, %0d forces compared", items_sent,
                 sets_sent, checked);
        $display("settings: reset, zero depth, full scale, zero sigma; overflow and stalls");
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ljp_pkg.sv
hdl/ljp_ram.sv
hdl/ljp_mul.sv
hdl/ljp_div.sv
hdl/ljp_front.sv
hdl/ljp_back.sv
hdl/lennard_jones_pair_forces_unit.sv
sim/ljp_force_checker.sv
sim/tb_lennard_jones_pair_forces_unit.sv
